>>> rtl/cpf_pkg.sv
// Shared types and constants for the compacting pool free block.
`default_nettype none

package cpf_pkg;

  // Store sizes
  localparam int HANDLE_COUNT   = 256;
  localparam int RESIDENT_SLOTS = 256;
  localparam int HIDX_W         = $clog2(HANDLE_COUNT);
  localparam int SIDX_W         = $clog2(RESIDENT_SLOTS);

  // Field constants
  localparam logic [15:0] END_MARK        = 16'hFFFF;
  localparam logic [15:0] FLAG_CLEAR_MASK = 16'h0003;
  localparam int          PARA_SHIFT      = 4;

  // Input actions (carried on tuser)
  typedef enum logic [1:0] {
    ACT_LOAD_ENTRY  = 2'd0,
    ACT_LOAD_SLOT   = 2'd1,
    ACT_LOAD_TOTALS = 2'd2,
    ACT_FREE        = 2'd3
  } action_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_SCMP,
    ST_SHIFT,
    ST_RRD,
    ST_EUPD0,
    ST_EUPD1,
    ST_DONE
  } state_e;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Handle table write request
  typedef struct packed {
    logic              we_seg;
    logic              we_flags;
    logic              we_size;
    logic [HIDX_W-1:0] addr;
    logic [15:0]       seg;
    logic [15:0]       flags;
    logic [31:0]       size;
  } entry_wr_t;

  // Handle table read request
  typedef struct packed {
    logic              re;
    logic [HIDX_W-1:0] addr;
  } entry_rd_t;

  // Handle table read data
  typedef struct packed {
    logic [15:0] seg;
    logic [15:0] flags;
    logic [31:0] size;
  } entry_data_t;

  // Resident list access
  typedef struct packed {
    logic              we;
    logic [SIDX_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [SIDX_W-1:0] raddr;
  } res_req_t;

endpackage

`default_nettype wire

>>> rtl/compacting_pool_free.sv
// Top level: sequencer for loads and handle frees of the compacting pool.
// Each beat on the input carries one action and yields exactly one result beat.
// A load action updates its store or totals and then hands off its result. A free
// runs a small sequencer around one shared 32-bit adder: it reads the handle entry
// and updates the free total, pool end and source segment (HDR0 to HDR2), then
// searches the resident slots in order up to and including the hit (SCMP), then
// rewrites each slot during the shift (SHIFT and RRD), counting the one that takes
// the end marker, with EUPD0 and EUPD1 added for each shifted entry that lies in
// the handle table. An absent handle costs a full search of all resident slots.
// The input is not ready until the current item's result is in the output register.
`default_nettype none

module compacting_pool_free (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] handle, [15:8] slot, [31:16] segment, [47:32] flag_bits,
  // [79:48] byte_size, [95:80] resident_value, [127:96] free_total_in,
  // [143:128] pool_end_in
  input  wire [143:0]  s_axis_tdata,
  // [1:0] action
  input  wire [1:0]    s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // [15:0] move_dest_segment, [31:16] move_src_segment, [63:32] move_byte_count,
  // [95:64] free_bytes_now, [111:96] pool_end_now
  output logic [111:0] m_axis_tdata,
  // [0] handle_found, [1] move_needed
  output logic [1:0]   m_axis_tuser
);
  import cpf_pkg::*;

  localparam logic [SIDX_W-1:0] LAST_SLOT = SIDX_W'(RESIDENT_SLOTS - 1);

  // Input field unpacking
  logic [7:0]  in_handle;
  logic [7:0]  in_slot;
  logic [15:0] in_segment;
  logic [15:0] in_flag_bits;
  logic [31:0] in_byte_size;
  logic [15:0] in_resident_value;
  logic [31:0] in_free_total;
  logic [15:0] in_pool_end;
  action_e     in_action;

  assign in_handle         = s_axis_tdata[7:0];
  assign in_slot           = s_axis_tdata[15:8];
  assign in_segment        = s_axis_tdata[31:16];
  assign in_flag_bits      = s_axis_tdata[47:32];
  assign in_byte_size      = s_axis_tdata[79:48];
  assign in_resident_value = s_axis_tdata[95:80];
  assign in_free_total     = s_axis_tdata[127:96];
  assign in_pool_end       = s_axis_tdata[143:128];
  assign in_action         = action_e'(s_axis_tuser);

  // State
  state_e            state_q, state_d;
  logic [SIDX_W-1:0] pos_q, pos_d;
  logic [HIDX_W-1:0] handle_q, handle_d;
  logic [HIDX_W-1:0] next_q, next_d;
  logic [15:0]       paras_q, paras_d;
  logic [15:0]       dest_q, dest_d;
  logic [15:0]       src_q, src_d;
  logic [31:0]       moved_q, moved_d;
  logic              found_q, found_d;
  logic [31:0]       free_total_q, free_total_d;
  logic [15:0]       pool_end_q, pool_end_d;
  logic              out_valid_q;
  logic              out_load;

  // Submodule connections
  entry_wr_t   ent_wr;
  entry_rd_t   ent_rd;
  entry_data_t ent_q;
  res_req_t    res_req;
  logic [15:0] res_rd;
  logic [31:0] alu_a, alu_b, alu_y;
  alu_op_e     alu_op;
  logic [15:0] next_val;
  logic        accept;

  cpf_entry_mem u_entry (
    .clk_i     (clk_i),
    .wr_i      (ent_wr),
    .rd_i      (ent_rd),
    .rd_data_o (ent_q)
  );

  cpf_resident u_resident (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (res_req),
    .rd_data_o (res_rd)
  );

  cpf_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .op_i (alu_op),
    .y_o  (alu_y)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // Value that moves into the current slot; past the last slot it is an end marker
  assign next_val = (pos_q == LAST_SLOT) ? END_MARK : res_rd;

  // Sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    handle_d     = handle_q;
    next_d       = next_q;
    paras_d      = paras_q;
    dest_d       = dest_q;
    src_d        = src_q;
    moved_d      = moved_q;
    found_d      = found_q;
    free_total_d = free_total_q;
    pool_end_d   = pool_end_q;
    ent_wr       = '0;
    ent_rd       = '0;
    res_req      = '0;
    alu_a        = moved_q;
    alu_b        = ent_q.size;
    alu_op       = ALU_ADD;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          handle_d = in_handle[HIDX_W-1:0];
          found_d  = 1'b0;
          moved_d  = '0;
          dest_d   = '0;
          src_d    = '0;
          state_d  = ST_DONE;
          unique case (in_action)
            ACT_LOAD_ENTRY: begin
              ent_wr.we_seg   = 1'b1;
              ent_wr.we_flags = 1'b1;
              ent_wr.we_size  = 1'b1;
              ent_wr.addr     = in_handle[HIDX_W-1:0];
              ent_wr.seg      = in_segment;
              ent_wr.flags    = in_flag_bits;
              ent_wr.size     = in_byte_size;
            end
            ACT_LOAD_SLOT: begin
              res_req.we    = 1'b1;
              res_req.waddr = in_slot[SIDX_W-1:0];
              res_req.wdata = in_resident_value;
            end
            ACT_LOAD_TOTALS: begin
              free_total_d = in_free_total;
              pool_end_d   = in_pool_end;
            end
            ACT_FREE: begin
              ent_rd.re   = 1'b1;
              ent_rd.addr = in_handle[HIDX_W-1:0];
              state_d     = ST_HDR0;
            end
            default: ;
          endcase
        end
      end
      // Entry data ready: latch destination and size, clear flags, grow free total
      ST_HDR0: begin
        dest_d          = ent_q.seg;
        paras_d         = ent_q.size[PARA_SHIFT+15:PARA_SHIFT];
        ent_wr.we_flags = 1'b1;
        ent_wr.addr     = handle_q;
        ent_wr.flags    = ent_q.flags & ~FLAG_CLEAR_MASK;
        alu_a           = free_total_q;
        alu_b           = ent_q.size;
        free_total_d    = alu_y;
        state_d         = ST_HDR1;
      end
      // Lower pool end
      ST_HDR1: begin
        alu_a      = 32'(pool_end_q);
        alu_b      = 32'(paras_q);
        alu_op     = ALU_SUB;
        pool_end_d = alu_y[15:0];
        state_d    = ST_HDR2;
      end
      // Source segment; start search at slot zero
      ST_HDR2: begin
        alu_a         = 32'(dest_q);
        alu_b         = 32'(paras_q);
        src_d         = alu_y[15:0];
        pos_d         = '0;
        res_req.re    = 1'b1;
        res_req.raddr = '0;
        state_d       = ST_SCMP;
      end
      // Compare slot pos; following slot is read in the same cycle
      ST_SCMP: begin
        res_req.re    = 1'b1;
        res_req.raddr = pos_q + SIDX_W'(1);
        if (res_rd == 16'(handle_q)) begin
          found_d = 1'b1;
          state_d = ST_SHIFT;
        end else if (pos_q == LAST_SLOT) begin
          state_d = ST_DONE;
        end else begin
          pos_d = pos_q + SIDX_W'(1);
        end
      end
      // Move following value down into slot pos
      ST_SHIFT: begin
        res_req.we    = 1'b1;
        res_req.waddr = pos_q;
        res_req.wdata = next_val;
        next_d        = next_val[HIDX_W-1:0];
        if (next_val[15]) begin
          state_d = ST_DONE;
        end else if (next_val[15:HIDX_W] == '0) begin
          ent_rd.re   = 1'b1;
          ent_rd.addr = next_val[HIDX_W-1:0];
          state_d     = ST_EUPD0;
        end else begin
          pos_d   = pos_q + SIDX_W'(1);
          state_d = ST_RRD;
        end
      end
      ST_RRD: begin
        res_req.re    = 1'b1;
        res_req.raddr = pos_q + SIDX_W'(1);
        state_d       = ST_SHIFT;
      end
      // Lower the shifted entry's segment
      ST_EUPD0: begin
        alu_a         = 32'(ent_q.seg);
        alu_b         = 32'(paras_q);
        alu_op        = ALU_SUB;
        ent_wr.we_seg = 1'b1;
        ent_wr.addr   = next_q;
        ent_wr.seg    = alu_y[15:0];
        state_d       = ST_EUPD1;
      end
      // Accumulate moved bytes and step to the next slot
      ST_EUPD1: begin
        alu_a   = moved_q;
        alu_b   = ent_q.size;
        moved_d = alu_y;
        pos_d   = pos_q + SIDX_W'(1);
        state_d = ST_RRD;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      free_total_q <= '0;
      pool_end_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_total_q <= free_total_d;
      pool_end_q   <= pool_end_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    handle_q <= handle_d;
    next_q   <= next_d;
    paras_q  <= paras_d;
    dest_q   <= dest_d;
    src_q    <= src_d;
    moved_q  <= moved_d;
    found_q  <= found_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= {pool_end_q, free_total_q, moved_q, src_q, dest_q};
      m_axis_tuser <= {(moved_q != '0), found_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;

`ifndef ASSERT_OFF
  // An accepted free always starts with the entry read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser == ACT_FREE)) |=> (state_q == ST_HDR0))
    else $error("free did not start entry read");

  // A shift step never wraps the slot index back to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RRD) |-> (pos_q != '0))
    else $error("resident shift wrapped slot index");

  // No bytes move unless the handle was found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[63:32] == '0))
    else $error("moved bytes without found handle");

  // Move flag agrees with the byte count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1] == (m_axis_tdata[63:32] != '0)))
    else $error("move flag mismatch");
`endif

endmodule

`default_nettype wire

>>> rtl/cpf_entry_mem.sv
// Handle table: segment, flags and size memories with registered read.
`default_nettype none

module cpf_entry_mem (
  input  wire                 clk_i,
  input  cpf_pkg::entry_wr_t  wr_i,
  input  cpf_pkg::entry_rd_t  rd_i,
  output cpf_pkg::entry_data_t rd_data_o
);
  import cpf_pkg::*;

  logic [15:0] seg_mem   [HANDLE_COUNT];
  logic [15:0] flags_mem [HANDLE_COUNT];
  logic [31:0] size_mem  [HANDLE_COUNT];
  entry_data_t rd_q;

  // Writes, one address per cycle, per-field enables
  always_ff @(posedge clk_i) begin
    if (wr_i.we_seg) begin
      seg_mem[wr_i.addr] <= wr_i.seg;
    end
    if (wr_i.we_flags) begin
      flags_mem[wr_i.addr] <= wr_i.flags;
    end
    if (wr_i.we_size) begin
      size_mem[wr_i.addr] <= wr_i.size;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rd_q.seg   <= seg_mem[rd_i.addr];
      rd_q.flags <= flags_mem[rd_i.addr];
      rd_q.size  <= size_mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> rtl/cpf_resident.sv
// Resident list memory with per-slot valid bits; unwritten slots read as end marker.
`default_nettype none

module cpf_resident (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cpf_pkg::res_req_t req_i,
  output logic [15:0]       rd_data_o
);
  import cpf_pkg::*;

  logic [15:0]               mem [RESIDENT_SLOTS];
  logic [RESIDENT_SLOTS-1:0] valid_q;
  logic [15:0]               rd_q;

  // Storage
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= valid_q[req_i.raddr] ? mem[req_i.raddr] : END_MARK;
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> rtl/cpf_alu.sv
// Shared 32-bit add/subtract unit used by the sequencer for the total, segment and byte-count updates.
`default_nettype none

module cpf_alu (
  input  wire [31:0]        a_i,
  input  wire [31:0]        b_i,
  input  cpf_pkg::alu_op_e  op_i,
  output logic [31:0]       y_o
);
  import cpf_pkg::*;

  always_comb begin
    case (op_i)
      ALU_SUB: y_o = a_i - b_i;
      default: y_o = a_i + b_i;
    endcase
  end

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the compacting pool free block: loads, frees and move requests.
`timescale 1ns / 1ps

module tb;
  import cpf_pkg::*;

  // One input beat; after the action, fields run from least to most significant on the bus
  typedef struct packed {
    action_e     act;
    logic [7:0]  handle;
    logic [7:0]  slot;
    logic [15:0] seg;
    logic [15:0] flags;
    logic [31:0] size;
    logic [15:0] res;
    logic [31:0] total;
    logic [15:0] pend;
  } pool_cmd_t;

  // One result beat
  typedef struct packed {
    logic        found;
    logic        need;
    logic [15:0] dest;
    logic [15:0] src;
    logic [31:0] moved;
    logic [31:0] free_now;
    logic [15:0] end_now;
  } move_result_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  compacting_pool_free uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mirror of the block's stores
  logic [15:0] ent_seg     [HANDLE_COUNT];
  logic [15:0] ent_flags   [HANDLE_COUNT];
  logic [31:0] ent_size    [HANDLE_COUNT];
  bit          ent_written [HANDLE_COUNT];
  logic [15:0] res_list    [RESIDENT_SLOTS];
  logic [31:0] free_bytes;
  logic [15:0] pool_end_seg;

  move_result_t pending_moves [$];

  int src_idle_pct = 17;
  int snk_idle_pct = 56;
  int sink_hold    = 0;
  int err_cnt      = 0;
  int beats_sent   = 0;
  int frees_sent   = 0;
  int frees_hit    = 0;
  int frees_moved  = 0;

  task automatic clear_pool_model();
    int k;
    for (k = 0; k < HANDLE_COUNT; k++) begin
      ent_seg[HIDX_W'(k)]     = '0;
      ent_flags[HIDX_W'(k)]   = '0;
      ent_size[HIDX_W'(k)]    = '0;
      ent_written[HIDX_W'(k)] = 1'b0;
    end
    for (k = 0; k < RESIDENT_SLOTS; k++) res_list[SIDX_W'(k)] = END_MARK;
    free_bytes   = '0;
    pool_end_seg = '0;
  endtask

  // Apply one accepted beat to the mirror and queue the move request it yields
  task automatic predict_move(pool_cmd_t c);
    move_result_t r;
    logic [15:0]  paras;
    logic [15:0]  nxt;
    int           pos;
    bit           done;
    r = '0;
    case (c.act)
      ACT_LOAD_ENTRY: begin
        ent_seg[c.handle]     = c.seg;
        ent_flags[c.handle]   = c.flags;
        ent_size[c.handle]    = c.size;
        ent_written[c.handle] = 1'b1;
      end
      ACT_LOAD_SLOT: res_list[c.slot] = c.res;
      ACT_LOAD_TOTALS: begin
        free_bytes   = c.total;
        pool_end_seg = c.pend;
      end
      default: begin
        frees_sent++;
        paras  = 16'(ent_size[c.handle] >> PARA_SHIFT);
        r.dest = ent_seg[c.handle];
        r.src  = r.dest + paras;
        ent_flags[c.handle] = ent_flags[c.handle] & ~FLAG_CLEAR_MASK;
        free_bytes   = free_bytes + ent_size[c.handle];
        pool_end_seg = pool_end_seg - paras;
        pos = 0;
        while (pos < RESIDENT_SLOTS && res_list[SIDX_W'(pos)] != {8'h00, c.handle}) pos++;
        if (pos < RESIDENT_SLOTS) begin
          // close the gap; later entries slide down in the pool
          r.found = 1'b1;
          done    = 1'b0;
          while (!done) begin
            nxt = (pos + 1 < RESIDENT_SLOTS) ? res_list[SIDX_W'(pos + 1)] : END_MARK;
            res_list[SIDX_W'(pos)] = nxt;
            if (nxt[15]) begin
              done = 1'b1;
            end else begin
              if (nxt < HANDLE_COUNT) begin
                ent_seg[nxt[7:0]] = ent_seg[nxt[7:0]] - paras;
                r.moved = r.moved + ent_size[nxt[7:0]];
              end
              pos++;
            end
          end
        end
        r.need = (r.moved != 0);
        if (r.found) frees_hit++;
        if (r.need) frees_moved++;
      end
    endcase
    r.free_now = free_bytes;
    r.end_now  = pool_end_seg;
    pending_moves.push_back(r);
  endtask

  // Returns -1 when a free of h reads only loaded entries, else an entry to load first
  function automatic int blocking_entry(logic [7:0] h);
    int          pos;
    int          blk;
    bit          done;
    logic [15:0] v;
    blk = -1;
    if (!ent_written[h]) begin
      blk = int'(h);
    end else begin
      pos = 0;
      while (pos < RESIDENT_SLOTS && res_list[SIDX_W'(pos)] != {8'h00, h}) pos++;
      pos++;
      done = 1'b0;
      while (!done && pos < RESIDENT_SLOTS) begin
        v = res_list[SIDX_W'(pos)];
        if (v[15]) begin
          done = 1'b1;
        end else if (v < HANDLE_COUNT && !ent_written[v[7:0]]) begin
          blk  = int'(v);
          done = 1'b1;
        end
        pos++;
      end
    end
    return blk;
  endfunction

  function automatic logic [31:0] rand_size();
    if ($urandom_range(99) < 12) return $urandom;
    return $urandom_range(0, 32'h0001_0000);
  endfunction

  function automatic pool_cmd_t rand_cmd();
    pool_cmd_t c;
    c.act    = action_e'($urandom_range(0, 3));
    c.handle = 8'($urandom);
    c.slot   = 8'($urandom);
    c.seg    = 16'($urandom);
    c.flags  = 16'($urandom);
    c.size   = rand_size();
    c.res    = 16'($urandom);
    c.total  = $urandom;
    c.pend   = 16'($urandom);
    return c;
  endfunction

  // Offer one beat, hold it until accepted, then predict
  task automatic send_item(pool_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.act;
    s_axis_tdata  <= {c.pend, c.total, c.res, c.size, c.flags, c.seg, c.slot, c.handle};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    predict_move(c);
  endtask

  task automatic send_entry(logic [7:0] h, logic [15:0] seg, logic [15:0] fl, logic [31:0] sz);
    pool_cmd_t c;
    c        = rand_cmd();
    c.act    = ACT_LOAD_ENTRY;
    c.handle = h;
    c.seg    = seg;
    c.flags  = fl;
    c.size   = sz;
    send_item(c);
  endtask

  task automatic send_slot(logic [7:0] s, logic [15:0] v);
    pool_cmd_t c;
    c      = rand_cmd();
    c.act  = ACT_LOAD_SLOT;
    c.slot = s;
    c.res  = v;
    send_item(c);
  endtask

  task automatic send_totals(logic [31:0] t, logic [15:0] e);
    pool_cmd_t c;
    c       = rand_cmd();
    c.act   = ACT_LOAD_TOTALS;
    c.total = t;
    c.pend  = e;
    send_item(c);
  endtask

  // A free that would read an unloaded entry turns into a load of that entry
  task automatic send_free(logic [7:0] h);
    pool_cmd_t c;
    int        blk;
    blk = blocking_entry(h);
    c   = rand_cmd();
    if (blk < 0) begin
      c.act    = ACT_FREE;
      c.handle = h;
    end else begin
      c.act    = ACT_LOAD_ENTRY;
      c.handle = blk[7:0];
    end
    send_item(c);
  endtask

  task automatic send_noise();
    pool_cmd_t c;
    c = rand_cmd();
    if (c.act == ACT_FREE) send_free(c.handle);
    else send_item(c);
  endtask

  function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
    end
  endfunction

  task automatic check_move();
    move_result_t got;
    move_result_t want;
    got.found    = m_axis_tuser[0];
    got.need     = m_axis_tuser[1];
    got.dest     = m_axis_tdata[15:0];
    got.src      = m_axis_tdata[31:16];
    got.moved    = m_axis_tdata[63:32];
    got.free_now = m_axis_tdata[95:64];
    got.end_now  = m_axis_tdata[111:96];
    if (pending_moves.size() == 0) begin
      err_cnt++;
      $display("%0t ns: result beat with none expected, actual %h", $time, got);
    end else begin
      want = pending_moves.pop_front();
      check_field("handle_found", 32'(want.found), 32'(got.found));
      check_field("move_needed", 32'(want.need), 32'(got.need));
      check_field("move_dest_segment", 32'(want.dest), 32'(got.dest));
      check_field("move_src_segment", 32'(want.src), 32'(got.src));
      check_field("move_byte_count", want.moved, got.moved);
      check_field("free_bytes_now", want.free_now, got.free_now);
      check_field("pool_end_now", 32'(want.end_now), 32'(got.end_now));
    end
  endtask

  // Result side: check each beat, then pick next ready (long hold-off when requested)
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_move();
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Extremes, wraparound, absent handle, end of list at the last slot, value past the table
  task automatic test_directed();
    send_totals(32'hFFFF_FFF0, 16'h0001);
    send_entry(8'h00, 16'hFFF0, 16'hFFFF, 32'hFFFF_FFFF);
    send_entry(8'hFF, 16'h0000, 16'h0000, 32'h0000_0000);
    send_entry(8'h5A, 16'h1234, 16'h0003, 32'h0000_0100);
    send_slot(8'd0, 16'h005A);
    send_slot(8'd1, 16'h0000);
    send_slot(8'd2, 16'h0123);
    send_slot(8'd3, 16'h00FF);
    send_slot(8'd4, 16'h8000);
    send_free(8'h5A);
    send_free(8'hFF);
    send_free(8'hFF);
    send_slot(8'd254, 16'h005A);
    send_slot(8'd255, 16'h00FF);
    send_free(8'h5A);
    send_free(8'h00);
    send_totals(32'h0000_0000, 16'h0000);
    send_entry(8'hA5, 16'h7FFF, 16'h5555, 32'h8000_000F);
    send_totals(32'hFFFF_FFFF, 16'hFFFF);
    send_free(8'hA5);
  endtask

  // Output held off long enough for the input to stall behind it
  task automatic test_backpressure();
    sink_hold = 300;
    repeat (8) send_entry(8'($urandom), 16'($urandom), 16'($urandom), rand_size());
  endtask

  // Build a short resident list, then free from it; some noise in between
  task automatic run_episode();
    logic [7:0]  hs [12];
    logic [15:0] v;
    int          n;
    int          k;
    n = $urandom_range(1, 10);
    for (k = 0; k < n; k++) begin
      hs[4'(k)] = 8'($urandom_range(0, 255));
      send_entry(hs[4'(k)], 16'($urandom), 16'($urandom), rand_size());
    end
    for (k = 0; k < n; k++) begin
      v = {8'h00, hs[4'(k)]};
      if ($urandom_range(99) < 5) v = 16'($urandom_range(256, 32767));
      send_slot(8'(k), v);
    end
    send_slot(8'(n), 16'h8000 | 16'($urandom_range(0, 32767)));
    if ($urandom_range(99) < 25) send_totals($urandom, 16'($urandom));
    repeat ($urandom_range(1, n + 1)) begin
      if ($urandom_range(99) < 85) send_free(hs[4'($urandom_range(0, n - 1))]);
      else send_free(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random(int n);
    int start;
    start = beats_sent;
    while (beats_sent - start < n) begin
      if ($urandom_range(99) < 85) run_episode();
      else repeat ($urandom_range(1, 4)) send_noise();
    end
  endtask

  initial begin
    clear_pool_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(280);
    src_idle_pct = 56;
    snk_idle_pct = 17;
    test_random(280);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(280);
    s_axis_tvalid <= 1'b0;

    // drain remaining results
    while (pending_moves.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("tb: %0d beats sent, %0d frees (%0d found, %0d with data to move)",
             beats_sent, frees_sent, frees_hit, frees_moved);
    $display("tb: covered field extremes, wraparound, absent handles, last-slot list end, stalls");
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("tb: timeout, %0d results outstanding", pending_moves.size());
    $display("tb: FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/cpf_pkg.sv
rtl/cpf_entry_mem.sv
rtl/cpf_resident.sv
rtl/cpf_alu.sv
rtl/compacting_pool_free.sv
dv/tb.sv
